### hw/rtl/ucl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UDP credit load balancer.
package ucl_pkg;

    localparam logic [10:0] MIN_FRAME_BYTES = 11'd46;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [7:0]  CREDIT_MAX      = 8'd255;

    localparam logic [15:0] RST_BALANCER_PORT    = 16'd11000;
    localparam logic [15:0] RST_SERVER_BASE_PORT = 16'd13000;
    localparam logic [7:0]  RST_SLOTS_PER_SERVER = 8'd5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCER_PORT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_BASE_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_SERVER = 2'd2;

    typedef enum logic [1:0] {
        VERDICT_PASS = 2'd0,
        VERDICT_DROP = 2'd1,
        VERDICT_TX   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [10:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] payload_word;
    } t_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] out_source_port;
        logic [15:0] out_dest_port;
        logic [31:0] out_payload_word;
    } t_result;

    typedef struct packed {
        logic [15:0] balancer_port;
        logic [15:0] server_base_port;
        logic [7:0]  slots_per_server;
    } t_cfg;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

    typedef struct packed {
        logic qualified;
        logic push;
        logic pop;
    } t_ring_op;

endpackage

### hw/rtl/ucl_if.sv
`timescale 1ns / 1ps
// Request, result and configuration channel interfaces of the load balancer.
interface ucl_req_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] payload_word;

    modport source (
        output valid, frame_length, ether_type, ip_protocol, source_port, dest_port,
        payload_word,
        input  ready
    );
    modport sink (
        input  valid, frame_length, ether_type, ip_protocol, source_port, dest_port,
        payload_word,
        output ready
    );
endinterface

interface ucl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [15:0] out_source_port;
    logic [15:0] out_dest_port;
    logic [31:0] out_payload_word;

    modport source (
        output valid, verdict, out_source_port, out_dest_port, out_payload_word,
        input  ready
    );
    modport sink (
        input  valid, verdict, out_source_port, out_dest_port, out_payload_word,
        output ready
    );
endinterface

interface ucl_cfg_if;
    logic        valid;
    logic        ready;
    logic [ucl_pkg::CFG_IDX_W-1:0] index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/ucl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ucl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ucl_decide.sv
`timescale 1ns / 1ps
// Per-frame decision logic: qualification, reply handling and server selection.
module ucl_decide #(
    parameter int SERVER_COUNT = 3
) (
    input  ucl_pkg::t_item      i_item,
    input  ucl_pkg::t_cfg       i_cfg,
    input  logic                i_loaded,
    input  logic [7:0]          i_credit [SERVER_COUNT],
    input  ucl_pkg::t_ring_stat i_ring,
    input  logic [31:0]         i_head_word,
    output ucl_pkg::t_result    o_result,
    output ucl_pkg::t_ring_op   o_op,
    output logic [7:0]          o_credit [SERVER_COUNT]
);

    logic                    qualified;
    logic [7:0]              eff [SERVER_COUNT];
    logic [SERVER_COUNT-1:0] match;
    logic [SERVER_COUNT-1:0] grant;
    logic                    any_match;
    logic                    found;
    logic [15:0]             grant_off;

    always_comb begin
        qualified = (i_item.frame_length >= ucl_pkg::MIN_FRAME_BYTES) &&
                    (i_item.ether_type == ucl_pkg::ETHERTYPE_IPV4) &&
                    (i_item.ip_protocol == ucl_pkg::PROTO_UDP) &&
                    (i_item.dest_port == i_cfg.balancer_port);

        // Server ports are formed without wrap, so a port above 65535 never matches.
        for (int i = 0; i < SERVER_COUNT; i++) begin
            eff[i]   = i_loaded ? i_credit[i] : i_cfg.slots_per_server;
            match[i] = (({1'b0, i_cfg.server_base_port} + 17'(i)) ==
                        {1'b0, i_item.source_port});
        end
        any_match = |match;

        found     = 1'b0;
        grant     = '0;
        grant_off = '0;
        for (int i = 0; i < SERVER_COUNT; i++) begin
            if (!found && (eff[i] != 8'd0)) begin
                found     = 1'b1;
                grant[i]  = 1'b1;
                grant_off = 16'(i);
            end
        end

        o_result.verdict          = ucl_pkg::VERDICT_PASS;
        o_result.out_source_port  = i_item.source_port;
        o_result.out_dest_port    = i_item.dest_port;
        o_result.out_payload_word = i_item.payload_word;
        o_op                      = '0;
        for (int i = 0; i < SERVER_COUNT; i++) begin
            o_credit[i] = i_credit[i];
        end

        if (qualified) begin
            o_op.qualified = 1'b1;
            for (int i = 0; i < SERVER_COUNT; i++) begin
                o_credit[i] = eff[i];
            end
            if (any_match) begin
                if (i_ring.empty) begin
                    o_result.verdict = ucl_pkg::VERDICT_DROP;
                    for (int i = 0; i < SERVER_COUNT; i++) begin
                        if (match[i] && (eff[i] != ucl_pkg::CREDIT_MAX)) begin
                            o_credit[i] = eff[i] + 8'd1;
                        end
                    end
                end else begin
                    o_result.verdict          = ucl_pkg::VERDICT_TX;
                    o_result.out_payload_word = i_head_word;
                    o_result.out_dest_port    = i_item.source_port;
                    o_result.out_source_port  = i_cfg.balancer_port;
                    o_op.pop                  = 1'b1;
                end
            end else if (found) begin
                o_result.verdict         = ucl_pkg::VERDICT_TX;
                o_result.out_dest_port   = i_cfg.server_base_port + grant_off;
                o_result.out_source_port = i_cfg.balancer_port;
                for (int i = 0; i < SERVER_COUNT; i++) begin
                    if (grant[i]) begin
                        o_credit[i] = eff[i] - 8'd1;
                    end
                end
            end else begin
                o_result.verdict = ucl_pkg::VERDICT_DROP;
                o_op.push        = !i_ring.full;
            end
        end
    end

endmodule

### hw/rtl/udp_credit_load_balancer_unit.sv
`timescale 1ns / 1ps
// Top level of the UDP credit load balancer.
// A request is taken into an input register, and its result is registered in an output register
// when that register is free or being read out; one request per cycle is sustained while o_rsp.ready
// stays high, set by the credit and ring pointer update that the decision stage makes per request.
// Reset is synchronous: control state, credits and pointers clear and the configuration
// returns to its defaults; the ring storage is not cleared and needs no clearing pass.
module udp_credit_load_balancer_unit #(
    parameter int SERVER_COUNT = 3,
    parameter int RING_DEPTH   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ucl_req_if.sink   i_req,
    ucl_rsp_if.source o_rsp,
    ucl_cfg_if.sink   i_cfg
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

    ucl_pkg::t_cfg       r_cfg;
    ucl_pkg::t_item      req_item;
    ucl_pkg::t_item      r_in;
    logic                r_in_valid;
    ucl_pkg::t_result    r_out;
    logic                r_out_valid;
    ucl_pkg::t_result    dec_result;
    ucl_pkg::t_ring_op   ring_op;
    ucl_pkg::t_ring_stat ring_stat;
    logic                r_loaded;
    logic [7:0]          r_credit [SERVER_COUNT];
    logic [7:0]          n_credit [SERVER_COUNT];
    logic [PW-1:0]       r_head;
    logic [PW-1:0]       r_tail;
    logic [PW-1:0]       n_head;
    logic [PW-1:0]       head_adv;
    logic [PW-1:0]       tail_adv;
    logic                do_proc;
    logic                in_ready;
    logic                wr_en;
    logic [31:0]         ram_rd_data;
    logic                r_byp;
    logic [31:0]         r_byp_data;
    logic [31:0]         head_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.balancer_port    <= ucl_pkg::RST_BALANCER_PORT;
            r_cfg.server_base_port <= ucl_pkg::RST_SERVER_BASE_PORT;
            r_cfg.slots_per_server <= ucl_pkg::RST_SLOTS_PER_SERVER;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ucl_pkg::CFG_BALANCER_PORT: begin
                    r_cfg.balancer_port <= i_cfg.data;
                end
                ucl_pkg::CFG_SERVER_BASE_PORT: begin
                    r_cfg.server_base_port <= i_cfg.data;
                end
                ucl_pkg::CFG_SLOTS_PER_SERVER: begin
                    r_cfg.slots_per_server <= i_cfg.data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        req_item.frame_length = i_req.frame_length;
        req_item.ether_type   = i_req.ether_type;
        req_item.ip_protocol  = i_req.ip_protocol;
        req_item.source_port  = i_req.source_port;
        req_item.dest_port    = i_req.dest_port;
        req_item.payload_word = i_req.payload_word;
    end

    assign do_proc     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_ready    = !r_in_valid || do_proc;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && in_ready) begin
            r_in <= req_item;
        end
    end

    assign head_adv        = (r_head == PTR_LAST) ? '0 : r_head + PW'(1);
    assign tail_adv        = (r_tail == PTR_LAST) ? '0 : r_tail + PW'(1);
    assign ring_stat.empty = (r_head == r_tail);
    assign ring_stat.full  = (tail_adv == r_head);

    // The oldest entry is read ahead; a write to that same entry is forwarded.
    assign head_word = r_byp ? r_byp_data : ram_rd_data;

    ucl_decide #(
        .SERVER_COUNT(SERVER_COUNT)
    ) u_decide (
        .i_item     (r_in),
        .i_cfg      (r_cfg),
        .i_loaded   (r_loaded),
        .i_credit   (r_credit),
        .i_ring     (ring_stat),
        .i_head_word(head_word),
        .o_result   (dec_result),
        .o_op       (ring_op),
        .o_credit   (n_credit)
    );

    assign wr_en  = do_proc && ring_op.push;
    assign n_head = (do_proc && ring_op.pop) ? head_adv : r_head;

    ucl_ram #(
        .WIDTH(32),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(r_in.payload_word),
        .i_rd_addr(n_head),
        .o_rd_data(ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_byp    <= 1'b0;
            for (int i = 0; i < SERVER_COUNT; i++) begin
                r_credit[i] <= '0;
            end
        end else begin
            r_head <= n_head;
            r_byp  <= wr_en && (r_tail == n_head);
            if (wr_en) begin
                r_tail <= tail_adv;
            end
            if (do_proc) begin
                r_loaded <= r_loaded | ring_op.qualified;
                for (int i = 0; i < SERVER_COUNT; i++) begin
                    r_credit[i] <= n_credit[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= r_in.payload_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_proc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_proc) begin
            r_out <= dec_result;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.verdict          = r_out.verdict;
    assign o_rsp.out_source_port  = r_out.out_source_port;
    assign o_rsp.out_dest_port    = r_out.out_dest_port;
    assign o_rsp.out_payload_word = r_out.out_payload_word;

endmodule
